>>> rtl/core/ake_pkg.sv
package ake_pkg;

	// Rounds expanded per key; the round key count is one more.
	localparam int unsigned NUM_ROUNDS = 10;
	localparam int unsigned NUM_WORDS  = 4;
	localparam int unsigned RND_W      = 4;

	typedef logic [RND_W-1:0] rnd_t;
	typedef logic [31:0]      word_t;

	// Per-cycle commands to the word cells.
	typedef struct packed {
		logic load;
		logic step;
	} cell_ctrl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX[b];
	endfunction

	// Round constant for the round that follows round key rnd.
	function automatic logic [7:0] rcon(input rnd_t rnd);
		logic [7:0] rc;
		unique case (rnd)
			4'd0:    rc = 8'h01;
			4'd1:    rc = 8'h02;
			4'd2:    rc = 8'h04;
			4'd3:    rc = 8'h08;
			4'd4:    rc = 8'h10;
			4'd5:    rc = 8'h20;
			4'd6:    rc = 8'h40;
			4'd7:    rc = 8'h80;
			4'd8:    rc = 8'h1b;
			4'd9:    rc = 8'h36;
			default: rc = 8'h00;
		endcase
		return rc;
	endfunction

endpackage

>>> rtl/core/ake_subword.sv
// RotWord, SubWord and round constant on the last word of the round key.
module ake_subword (
	input  ake_pkg::word_t w_last,
	input  ake_pkg::rnd_t  rnd,
	output ake_pkg::word_t core_word
);

	ake_pkg::word_t rot;

	assign rot = {w_last[23:0], w_last[31:24]};

	assign core_word = {ake_pkg::sbox(rot[31:24]) ^ ake_pkg::rcon(rnd),
	                    ake_pkg::sbox(rot[23:16]),
	                    ake_pkg::sbox(rot[15:8]),
	                    ake_pkg::sbox(rot[7:0])};

endmodule

>>> rtl/core/ake_word_cell.sv
// One word of the round key; its next value is its own word XOR the
// next value handed on by the left neighbour.
module ake_word_cell (
	input  logic               clk,
	input  ake_pkg::cell_ctrl_t ctrl,
	input  ake_pkg::word_t     key_word,
	input  ake_pkg::word_t     chain_in,
	output ake_pkg::word_t     chain_out,
	output ake_pkg::word_t     word
);

	ake_pkg::word_t word_q;

	assign chain_out = word_q ^ chain_in;
	assign word      = word_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= key_word;
		end else if (ctrl.step) begin
			word_q <= chain_out;
		end
	end

endmodule

>>> rtl/core/aes128_key_expansion_top.sv
// AES-128 key schedule: one key in, eleven round keys out, one per cycle.
// Round key 0 appears the cycle after the start transaction and the rest
// follow in order; a new key can be taken while the final round key is
// shown, as the word-cell chain steps one round per cycle.
// The receiver cannot stall: each round key is shown for one cycle only.
// Reset (arst_n low, asynchronous) clears the sequencer; the block is idle.
module aes128_key_expansion_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] key_high,
	input  logic [63:0] key_low,
	output logic        valid,
	output logic [3:0]  round_index,
	output logic [63:0] round_key_high,
	output logic [63:0] round_key_low,
	output logic        last
);

	// Round count held to 1..10 so the round constant never runs off its list.
	localparam ake_pkg::rnd_t LAST_RND = ake_pkg::rnd_t'((ake_pkg::NUM_ROUNDS < 1) ? 1 :
		((ake_pkg::NUM_ROUNDS > 10) ? 10 : ake_pkg::NUM_ROUNDS));

	// Sequencer state: a run is active while round keys are being shown.
	logic          active_q;
	ake_pkg::rnd_t rnd_q;
	logic          is_last;
	logic          accept;

	ake_pkg::cell_ctrl_t ctrl;
	ake_pkg::word_t      core_word;
	ake_pkg::word_t      key_words [ake_pkg::NUM_WORDS];
	ake_pkg::word_t      chain     [ake_pkg::NUM_WORDS+1];
	ake_pkg::word_t      words     [ake_pkg::NUM_WORDS];

	assign is_last = active_q && (rnd_q == LAST_RND);

	// Free during the final round key, so back-to-back keys run without a gap.
	assign busy   = active_q && !is_last;
	assign accept = start && !busy;

	assign ctrl.load = accept;
	assign ctrl.step = active_q && !is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			rnd_q    <= '0;
		end else begin
			if (accept) begin
				active_q <= 1'b1;
				rnd_q    <= '0;
			end else if (is_last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				rnd_q <= rnd_q + 1'b1;
			end
		end
	end

	assign key_words[0] = key_high[63:32];
	assign key_words[1] = key_high[31:0];
	assign key_words[2] = key_low[63:32];
	assign key_words[3] = key_low[31:0];

	// Head of the chain: transformed last word feeds word 0.
	ake_subword u_subword (
		.w_last    (words[ake_pkg::NUM_WORDS-1]),
		.rnd       (rnd_q),
		.core_word (core_word)
	);

	assign chain[0] = core_word;

	for (genvar i = 0; i < ake_pkg::NUM_WORDS; i++) begin : g_cell
		ake_word_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.key_word  (key_words[i]),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.word      (words[i])
		);
	end

	// Results come straight off the cell registers.
	assign valid          = active_q;
	assign round_index    = rnd_q;
	assign round_key_high = {words[0], words[1]};
	assign round_key_low  = {words[2], words[3]};
	assign last           = is_last;

	// A start transaction is followed by round key 0.
	a_start_round0: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid && (round_index == '0))
		else $error("round key 0 did not follow start");

	// Round numbers advance by one within a run.
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !last |=> valid && (round_index == $past(round_index) + 1'b1))
		else $error("round index did not advance");

	// The round index never passes the last round.
	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (round_index <= LAST_RND))
		else $error("round index out of range");

	// Busy is never seen without an active run.
	a_busy_active: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> valid && !last)
		else $error("busy outside a run");

endmodule
